// ===== hw/rtl/dnp_pkg.sv =====
// Shared definitions for the ASCII decimal number parser.
// Token phase codes, status codes, character codes, the per-token control
// record and the fraction weight table. No dependencies.
`default_nettype none

package dnp_pkg;

  // Default geometry of the fixed point result
  localparam int FRAC_BITS_DEF = 16;
  localparam int INT_BITS_DEF  = 31;
  localparam int VALUE_W       = 48;
  localparam int COUNT_W       = 8;
  localparam int FSUM_W        = 32;

  // Token phase codes
  localparam logic [1:0] PH_INT  = 2'd0;
  localparam logic [1:0] PH_FRAC = 2'd1;
  localparam logic [1:0] PH_STOP = 2'd2;
  localparam logic [1:0] PH_BAD  = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Character codes
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_POINT = 8'h2E;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;

  // Fraction digits after which the weight has truncated to zero
  localparam logic [3:0] WEIGHT_STEPS = 4'd10;

  // Control part of the token state
  typedef struct packed {
    logic [1:0]         phase;
    logic               negative;
    logic               position;
    logic               overflowed;
    logic [3:0]         frac_idx;
    logic [COUNT_W-1:0] count;
  } dnp_ctrl_t;

  localparam dnp_ctrl_t CTRL_RESET = '{
    phase:      PH_INT,
    negative:   1'b0,
    position:   1'b1,
    overflowed: 1'b0,
    frac_idx:   4'd0,
    count:      '0
  };

  // Weight of the k-th fraction digit in 0.32 format: one, divided by ten
  // k times with truncation at each step
  function automatic logic [FSUM_W-1:0] frac_weight(input logic [3:0] idx);
    logic [FSUM_W-1:0] w;
    case (idx)
      4'd1:    w = 32'd429496729;
      4'd2:    w = 32'd42949672;
      4'd3:    w = 32'd4294967;
      4'd4:    w = 32'd429496;
      4'd5:    w = 32'd42949;
      4'd6:    w = 32'd4294;
      4'd7:    w = 32'd429;
      4'd8:    w = 32'd42;
      4'd9:    w = 32'd4;
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/dnp_step.sv =====
// Per-character update of the token state of the decimal number parser.
// Purely combinational; depends on dnp_pkg.
`default_nettype none

module dnp_step #(
  parameter int INT_BITS = dnp_pkg::INT_BITS_DEF
) (
  input  dnp_pkg::dnp_ctrl_t         ctrl_i,
  input  logic [INT_BITS-1:0]        int_sum_i,
  input  logic [dnp_pkg::FSUM_W-1:0] frac_sum_i,
  input  logic [7:0]                 char_i,
  input  logic                       strict_i,
  output dnp_pkg::dnp_ctrl_t         ctrl_o,
  output logic [INT_BITS-1:0]        int_sum_o,
  output logic [dnp_pkg::FSUM_W-1:0] frac_sum_o
);
  import dnp_pkg::*;

  localparam int NV_W = INT_BITS + 4;

  logic              is_digit;
  logic [3:0]        digit;
  logic              is_sign;
  logic [NV_W-1:0]   int_next;
  logic [3:0]        idx_next;
  logic [FSUM_W+3:0] frac_prod;
  logic              taken;

  // Classify the character
  assign is_digit = (char_i >= CH_ZERO) && (char_i <= CH_NINE);
  assign digit    = is_digit ? 4'(char_i - CH_ZERO) : 4'd0;
  assign is_sign  = (char_i == CH_MINUS) || (char_i == CH_PLUS);

  // Integer accumulate: times ten as shift and add
  assign int_next = (NV_W'(int_sum_i) << 3) + (NV_W'(int_sum_i) << 1) + NV_W'(digit);

  // Fraction accumulate with the weight of the next digit
  assign idx_next  = (ctrl_i.frac_idx < WEIGHT_STEPS) ? ctrl_i.frac_idx + 4'd1
                                                      : ctrl_i.frac_idx;
  assign frac_prod = (FSUM_W+4)'(frac_weight(idx_next)) * (FSUM_W+4)'(digit);

  always_comb begin
    ctrl_o          = ctrl_i;
    int_sum_o       = int_sum_i;
    frac_sum_o      = frac_sum_i;
    taken           = 1'b0;
    ctrl_o.position = 1'b0;
    if (ctrl_i.phase == PH_INT || ctrl_i.phase == PH_FRAC) begin
      if (ctrl_i.position && is_sign) begin
        ctrl_o.negative = (char_i == CH_MINUS);
        taken           = 1'b1;
      end else if (is_digit && ctrl_i.phase == PH_INT) begin
        // Saturate the integer part at all ones
        if (int_next > NV_W'({INT_BITS{1'b1}})) begin
          int_sum_o         = {INT_BITS{1'b1}};
          ctrl_o.overflowed = 1'b1;
        end else begin
          int_sum_o = int_next[INT_BITS-1:0];
        end
        taken = 1'b1;
      end else if (is_digit) begin
        ctrl_o.frac_idx = idx_next;
        frac_sum_o      = frac_sum_i + frac_prod[FSUM_W-1:0];
        taken           = 1'b1;
      end else if (char_i == CH_POINT && ctrl_i.phase == PH_INT) begin
        ctrl_o.phase = PH_FRAC;
        taken        = 1'b1;
      end

      // Count taken characters, otherwise stop or fault
      if (taken) begin
        if (ctrl_i.count != {COUNT_W{1'b1}}) begin
          ctrl_o.count = ctrl_i.count + 1'b1;
        end
      end else begin
        ctrl_o.phase = strict_i ? PH_BAD : PH_STOP;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/decimal_number_parser.sv =====
// Top level of the ASCII decimal number parser: input register, token state,
// result register and configuration port. Depends on dnp_pkg and dnp_step.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-------------------------------
//   input    | in_valid_i / in_stall_o      | character_i, last_i
//   result   | out_valid_o / out_stall_i    | value_o, consumed_o, status_o
//   config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// One character is taken per cycle unless the input stalls; a character is
// processed from the input register, and a token's result is loaded into the
// output register at the edge ending the cycle its last character is processed.
// Reset clears the token state and sets strict mode off.
// The input stalls only while a last character waits behind a result that
// the receiver has not yet taken.
`default_nettype none

module decimal_number_parser #(
  parameter int FRAC_BITS = dnp_pkg::FRAC_BITS_DEF,
  parameter int INT_BITS  = dnp_pkg::INT_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // character input
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [7:0]                  character_i,
  input  logic                        last_i,
  // result output
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [dnp_pkg::VALUE_W-1:0] value_o,
  output logic [dnp_pkg::COUNT_W-1:0] consumed_o,
  output logic [1:0]                  status_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [1:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import dnp_pkg::*;

  localparam int MAG_W = INT_BITS + FRAC_BITS;

  logic                in_valid_q;
  logic [7:0]          char_q;
  logic                last_q;
  logic                strict_q;
  dnp_ctrl_t           ctrl_q, ctrl_d;
  logic [INT_BITS-1:0] int_sum_q, int_sum_d;
  logic [FSUM_W-1:0]   frac_sum_q, frac_sum_d;
  logic                proc;
  logic [MAG_W-1:0]    mag;
  logic [63:0]         mag_ext;
  logic [63:0]         signed_val;
  logic                out_valid_q;
  logic [VALUE_W-1:0]  value_q;
  logic [COUNT_W-1:0]  consumed_q;
  logic [1:0]          status_q;

  // Configuration register: a single register, byte lanes ignored
  assign pready = 1'b1;
  assign prdata = {31'd0, strict_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strict_q <= 1'b0;
    end else if (psel && penable && pwrite && pready && paddr == 2'd0) begin
      strict_q <= pwdata[0];
    end
  end

  // Process the held character unless it ends a token and the result is blocked
  assign proc       = in_valid_q && (!last_q || !out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      char_q <= character_i;
      last_q <= last_i;
    end
  end

  dnp_step #(
    .INT_BITS (INT_BITS)
  ) u_step (
    .ctrl_i     (ctrl_q),
    .int_sum_i  (int_sum_q),
    .frac_sum_i (frac_sum_q),
    .char_i     (char_q),
    .strict_i   (strict_q),
    .ctrl_o     (ctrl_d),
    .int_sum_o  (int_sum_d),
    .frac_sum_o (frac_sum_d)
  );

  // Token state: advance per character, clear after the last one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q     <= CTRL_RESET;
      int_sum_q  <= '0;
      frac_sum_q <= '0;
    end else if (proc) begin
      if (last_q) begin
        ctrl_q     <= CTRL_RESET;
        int_sum_q  <= '0;
        frac_sum_q <= '0;
      end else begin
        ctrl_q     <= ctrl_d;
        int_sum_q  <= int_sum_d;
        frac_sum_q <= frac_sum_d;
      end
    end
  end

  // Form the fixed point magnitude and apply the sign
  assign mag        = {int_sum_d, frac_sum_d[FSUM_W-1 -: FRAC_BITS]};
  assign mag_ext    = 64'(mag);
  assign signed_val = ctrl_d.negative ? (64'd0 - mag_ext) : mag_ext;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc && last_q) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc && last_q) begin
      consumed_q <= ctrl_d.count;
      if (ctrl_d.phase == PH_BAD) begin
        value_q  <= '0;
        status_q <= ST_INVALID;
      end else begin
        value_q  <= signed_val[VALUE_W-1:0];
        status_q <= ctrl_d.overflowed ? ST_OVERFLOW : ST_OK;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign consumed_o  = consumed_q;
  assign status_o    = status_q;

`ifndef NO_ASSERTIONS
  // Input stalls only behind a blocked result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && last_q && out_valid_o && out_stall_i))
    else $error("input stalled without a blocked result");

  // Token state is clear after a last character is processed
  a_token_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && last_q) |=> (ctrl_q.phase == PH_INT && ctrl_q.count == '0
                          && int_sum_q == '0 && ctrl_q.position))
    else $error("token state not cleared after result");

  // An invalid token reports zero
  a_invalid_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o == ST_INVALID) |-> (value_o == '0))
    else $error("invalid token with nonzero value");

  // Fraction digit index never passes the last weight
  a_frac_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_q.frac_idx <= WEIGHT_STEPS)
    else $error("fraction index out of range");

  // A result is loaded only when the previous one has gone or is going
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (proc && last_q) |-> (!out_valid_o || !out_stall_i))
    else $error("result overwritten while held");
`endif

endmodule

`default_nettype wire

// ===== sim/tb_decimal_number_parser.sv =====
// Self-checking testbench for decimal_number_parser: drives ASCII tokens, predicts each
// result in the bench and compares every result transfer field by field.
// Depends on dnp_pkg and the decimal_number_parser RTL.
`default_nettype none

module tb_decimal_number_parser;
  timeunit 1ns;
  timeprecision 1ps;

  import dnp_pkg::*;

  localparam int SETTLE = 8;
  localparam logic [63:0] INT_TOP = (64'd1 << INT_BITS_DEF) - 64'd1;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } char_item_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic [COUNT_W-1:0] consumed;
    logic [1:0]         status;
  } num_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i = 1'b0;
  logic               in_stall_o;
  logic [7:0]         character_i = 8'h00;
  logic               last_i = 1'b0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  logic [VALUE_W-1:0] value_o;
  logic [COUNT_W-1:0] consumed_o;
  logic [1:0]         status_o;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [1:0]         paddr = 2'd0;
  logic [31:0]        pwdata = 32'd0;
  logic [31:0]        prdata;
  logic               pready;

  decimal_number_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .character_i (character_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .consumed_o  (consumed_o),
    .status_o    (status_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Characters waiting to be driven and results still owed by the parser
  char_item_t  char_q[$];
  num_result_t parsed_q[$];
  int          queued_cnt = 0;
  int          taken_cnt  = 0;
  int          fails      = 0;
  int          cyc        = 0;
  logic        calm;

  // Bench copy of the token state and the mode register
  logic [1:0]  tok_phase;
  logic        tok_neg;
  logic [63:0] tok_int;
  logic [31:0] tok_frac;
  logic [63:0] tok_weight;
  int          tok_count;
  logic        tok_first;
  logic        tok_ovf;
  logic        strict_mode = 1'b0;

  always @(posedge clk_i) cyc <= cyc + 1;
  assign calm = (cyc >= 300) && (cyc < 900);

  function automatic void restart_token();
    tok_phase  = PH_INT;
    tok_neg    = 1'b0;
    tok_int    = '0;
    tok_frac   = '0;
    tok_weight = 64'h1_0000_0000;
    tok_count  = 0;
    tok_first  = 1'b1;
    tok_ovf    = 1'b0;
  endfunction

  // Advance the token by one character; on the last one, owe a result
  function automatic void parse_char(input logic [7:0] c, input logic lst);
    logic        digit;
    logic        taken;
    logic [63:0] d;
    logic [63:0] nv;
    logic [63:0] mag;
    logic [63:0] val;
    num_result_t r;
    digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d     = digit ? 64'(c - CH_ZERO) : 64'd0;
    taken = 1'b0;
    if (tok_phase == PH_INT || tok_phase == PH_FRAC) begin
      if (tok_first && (c == CH_MINUS || c == CH_PLUS)) begin
        tok_neg = (c == CH_MINUS);
        taken   = 1'b1;
      end else if (digit && tok_phase == PH_INT) begin
        nv = tok_int * 64'd10 + d;
        if (nv > INT_TOP) begin
          nv      = INT_TOP;
          tok_ovf = 1'b1;
        end
        tok_int = nv;
        taken   = 1'b1;
      end else if (digit) begin
        tok_weight = tok_weight / 64'd10;
        tok_frac   = 32'(64'(tok_frac) + tok_weight * d);
        taken      = 1'b1;
      end else if (c == CH_POINT && tok_phase == PH_INT) begin
        tok_phase = PH_FRAC;
        taken     = 1'b1;
      end
      if (taken) begin
        if (tok_count < 511) tok_count++;
      end else begin
        tok_phase = strict_mode ? PH_BAD : PH_STOP;
      end
    end
    tok_first = 1'b0;
    if (lst) begin
      mag = (tok_int << FRAC_BITS_DEF) + (64'(tok_frac) >> (FSUM_W - FRAC_BITS_DEF));
      val = tok_neg ? (64'd0 - mag) : mag;
      r.value    = val[VALUE_W-1:0];
      r.consumed = (tok_count > 255) ? 8'd255 : 8'(tok_count);
      r.status   = tok_ovf ? ST_OVERFLOW : ST_OK;
      if (tok_phase == PH_BAD) begin
        r.value  = '0;
        r.status = ST_INVALID;
      end
      parsed_q.push_back(r);
      restart_token();
    end
  endfunction

  // Character driver: predict on each transfer, then offer the next character
  always @(posedge clk_i) begin
    char_item_t it;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        parse_char(character_i, last_i);
        taken_cnt++;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (char_q.size() != 0 && (calm || $urandom_range(99) >= 10)) begin
          it = char_q.pop_front();
          in_valid_i  <= 1'b1;
          character_i <= it.ch;
          last_i      <= it.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest owed result
  always @(posedge clk_i) begin
    num_result_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (parsed_q.size() == 0) begin
          $error("unexpected result: value %h consumed %0d status %0d",
                 value_o, consumed_o, status_o);
          fails++;
        end else begin
          want = parsed_q.pop_front();
          if (value_o !== want.value) begin
            $error("value: expected %h, got %h", want.value, value_o);
            fails++;
          end
          if (consumed_o !== want.consumed) begin
            $error("consumed: expected %0d, got %0d", want.consumed, consumed_o);
            fails++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            fails++;
          end
        end
      end
      out_stall_i <= !calm && ($urandom_range(99) < 10);
    end
  end

  task automatic push_char(input logic [7:0] c, input logic lst);
    char_item_t it;
    it.ch   = c;
    it.last = lst;
    char_q.push_back(it);
    queued_cnt++;
  endtask

  task automatic push_text(input string s, input logic lst);
    for (int i = 0; i < s.len(); i++) push_char(s[i], lst && (i == s.len() - 1));
  endtask

  function automatic logic [7:0] odd_char();
    case ($urandom_range(3))
      0, 1:    return 8'($urandom_range(255));
      2:       return CH_POINT;
      default: return $urandom_range(1) ? CH_MINUS : CH_PLUS;
    endcase
  endfunction

  function automatic logic [7:0] rand_digit();
    return CH_ZERO + 8'($urandom_range(9));
  endfunction

  // Build one token: mostly well formed, some with a stray character, some noise
  task automatic gen_token(input logic lengthy);
    logic [7:0] tok[$];
    int kind;
    int n;
    int pos;
    kind = $urandom_range(99);
    if (lengthy || kind < 88) begin
      if (lengthy || $urandom_range(2) == 0)
        tok.push_back($urandom_range(1) ? CH_MINUS : CH_PLUS);
      n = lengthy ? 12 : (($urandom_range(15) == 0) ? $urandom_range(14, 10)
                                                     : $urandom_range(6));
      repeat (n) tok.push_back(rand_digit());
      if (lengthy || $urandom_range(1)) begin
        tok.push_back(CH_POINT);
        n = lengthy ? 250 : (($urandom_range(15) == 0) ? $urandom_range(14, 10)
                                                        : $urandom_range(7));
        repeat (n) tok.push_back(rand_digit());
      end
      if (tok.size() == 0) tok.push_back(rand_digit());
      if (!lengthy && kind >= 70) begin
        pos = $urandom_range(tok.size());
        tok.insert(pos, odd_char());
      end
    end else begin
      n = $urandom_range(6, 1);
      repeat (n) tok.push_back(odd_char());
    end
    foreach (tok[i]) push_char(tok[i], i == tok.size() - 1);
  endtask

  // Hold until every character is taken and every result checked, then settle
  task automatic drain();
    while (taken_cnt != queued_cnt || parsed_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_mode(input logic mode);
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= 2'd0;
    pwdata  <= ($urandom() & ~32'd1) | 32'(mode);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel        <= 1'b0;
    penable     <= 1'b0;
    pwrite      <= 1'b0;
    strict_mode = mode;
  endtask

  initial begin
    int start;
    restart_token();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Prefix mode after reset: sign, point, fraction, lone sign and point,
    // top byte as a stop, negative zero, misplaced sign, second point
    push_text("-12.5", 1'b1);
    push_text("+", 1'b1);
    push_text(".", 1'b1);
    push_char(CH_ZERO + 8'd7, 1'b0);
    push_char(8'hFF, 1'b1);
    push_text("-0", 1'b1);
    push_text("1-", 1'b1);
    push_text("1..", 1'b1);
    // leave a token open across the mode change
    push_text("5", 1'b0);
    drain();

    // Strict mode: zero byte finishes the open token as invalid, then overflow
    write_mode(1'b1);
    push_char(8'h00, 1'b1);
    push_text("9999999999", 1'b1);
    drain();

    // Random phases, alternating modes; some end with a token still open
    for (int p = 0; p < 6; p++) begin
      write_mode(p[0]);
      start = queued_cnt;
      if (p == 3) gen_token(1'b1);
      while (queued_cnt - start < 80) gen_token($urandom_range(149) == 0);
      if ($urandom_range(1)) push_char($urandom_range(1) ? rand_digit() : CH_MINUS, 1'b0);
      drain();
    end

    if (fails == 0 && parsed_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
